[rtl/msmh_pkg.sv]
// Shared types, register map and reset constants for the multiply-shift-mix hash.
package msmh_pkg;

   localparam int unsigned CsrAddrWidth = 6;
   localparam int unsigned CsrDataWidth = 64;

   localparam logic [31:0] CoefAReset   = 32'd2561893793;
   localparam logic [31:0] CoefBReset   = 32'd1388747947;
   localparam logic [31:0] CoefCReset   = 32'd3077216833;
   localparam logic [31:0] CoefDReset   = 32'd3427609723;
   localparam logic [63:0] SeedLowReset  = 64'hC726_5595_564A_4447;
   localparam logic [63:0] SeedHighReset = 64'h128F_A608_E20C_241D;

   typedef enum logic [2:0] {
      REG_COEF_A    = 3'd0,
      REG_COEF_B    = 3'd1,
      REG_COEF_C    = 3'd2,
      REG_COEF_D    = 3'd3,
      REG_SEED_LOW  = 3'd4,
      REG_SEED_HIGH = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } coef_type;

   // Two 128-bit states, each as a low and a high 64-bit lane.
   typedef struct packed {
      logic [63:0] s1_lo;
      logic [63:0] s1_hi;
      logic [63:0] s2_lo;
      logic [63:0] s2_hi;
   } lanes_type;

endpackage

[rtl/multiply_shift_mix_hash_128.sv]
// Top level of the multiply-shift-mix hash over 16-byte blocks.
// Throughput: one item per cycle while req_stall is low; the state register and
// its single mix round close the loop that sets this, while finalisation runs in
// its own stages. Reset clears all valid flags and the message flag and loads the
// reset values of the coefficient and seed registers; the state register is not
// reset, and the next message starts from the seed.
module multiply_shift_mix_hash_128 (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_low,
   input  logic [63:0] req_block_high,
   input  logic        req_has_block,
   input  logic        req_is_last,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [msmh_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [msmh_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [msmh_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                pready
);

   // Configuration registers.
   msmh_pkg::coef_type      coef_ff;
   logic [63:0]             seed_lo_ff;
   logic [63:0]             seed_hi_ff;
   msmh_pkg::reg_index_type csr_index;
   logic                    csr_write;

   // Input stage: block products and item flags.
   logic                    inp_v_ff;
   msmh_pkg::lanes_type     inp_prod_ff;
   msmh_pkg::lanes_type     inp_prod_in;
   logic                    inp_has_ff;
   logic                    inp_last_ff;

   // Running state.
   logic                    in_message_ff;
   msmh_pkg::lanes_type     state_ff;
   msmh_pkg::lanes_type     state_base;
   msmh_pkg::lanes_type     state_mixed;
   msmh_pkg::lanes_type     state_in;

   // Finalisation stages.
   logic                    fin_v_ff;
   logic [63:0]             fin_fake_lo_ff;
   logic [63:0]             fin_fake_hi_ff;
   msmh_pkg::lanes_type     fin_st_ff;
   logic                    fpr_v_ff;
   msmh_pkg::lanes_type     fpr_prod_ff;
   msmh_pkg::lanes_type     fpr_prod_in;
   msmh_pkg::lanes_type     fpr_st_ff;
   msmh_pkg::lanes_type     fin_res;

   logic                    rsp_valid_ff;
   logic [31:0]             rsp_hash_ff;

   logic                    out_ready;
   logic                    fpr_ready;
   logic                    fin_ready;
   logic                    inp_go;
   logic                    inp_ready;
   logic                    inp_active;
   logic                    req_xfer;

   // ---------------------------------------------------------------- CSR port
   assign pready    = 1'b1;
   assign csr_index = msmh_pkg::reg_index_type'(paddr[5:3]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      case (csr_index)
         msmh_pkg::REG_COEF_A:    prdata = {32'd0, coef_ff.a};
         msmh_pkg::REG_COEF_B:    prdata = {32'd0, coef_ff.b};
         msmh_pkg::REG_COEF_C:    prdata = {32'd0, coef_ff.c};
         msmh_pkg::REG_COEF_D:    prdata = {32'd0, coef_ff.d};
         msmh_pkg::REG_SEED_LOW:  prdata = seed_lo_ff;
         msmh_pkg::REG_SEED_HIGH: prdata = seed_hi_ff;
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.a  <= msmh_pkg::CoefAReset;
         coef_ff.b  <= msmh_pkg::CoefBReset;
         coef_ff.c  <= msmh_pkg::CoefCReset;
         coef_ff.d  <= msmh_pkg::CoefDReset;
         seed_lo_ff <= msmh_pkg::SeedLowReset;
         seed_hi_ff <= msmh_pkg::SeedHighReset;
      end else if (csr_write) begin
         case (csr_index)
            msmh_pkg::REG_COEF_A:    coef_ff.a  <= pwdata[31:0];
            msmh_pkg::REG_COEF_B:    coef_ff.b  <= pwdata[31:0];
            msmh_pkg::REG_COEF_C:    coef_ff.c  <= pwdata[31:0];
            msmh_pkg::REG_COEF_D:    coef_ff.d  <= pwdata[31:0];
            msmh_pkg::REG_SEED_LOW:  seed_lo_ff <= pwdata;
            msmh_pkg::REG_SEED_HIGH: seed_hi_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- flow control
   // Each stage moves when it is empty or the stage after it moves, so bubbles
   // close up while a result waits to be taken.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign fpr_ready  = !fpr_v_ff || out_ready;
   assign fin_ready  = !fin_v_ff || fpr_ready;
   // Only a last item needs room in the finalisation stage.
   assign inp_go     = inp_v_ff && (!inp_last_ff || fin_ready);
   assign inp_ready  = !inp_v_ff || inp_go;
   assign inp_active = inp_go && (inp_has_ff || inp_last_ff);
   assign req_stall  = !inp_ready;
   assign req_xfer   = req_valid && inp_ready;

   // ------------------------------------------------------------ input stage
   msmh_mul u_blk_mul (
      .coef  (coef_ff),
      .in_lo (req_block_low),
      .in_hi (req_block_high),
      .prod  (inp_prod_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         inp_v_ff <= 1'b0;
      end else if (inp_ready) begin
         inp_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         inp_prod_ff <= inp_prod_in;
         inp_has_ff  <= req_has_block;
         inp_last_ff <= req_is_last;
      end
   end

   // ------------------------------------------------------------ state loop
   always_comb begin
      if (in_message_ff) begin
         state_base = state_ff;
      end else begin
         state_base.s1_lo = seed_lo_ff;
         state_base.s1_hi = seed_hi_ff;
         state_base.s2_lo = seed_lo_ff;
         state_base.s2_hi = seed_hi_ff;
      end
   end

   msmh_mix u_blk_mix (
      .st   (state_base),
      .prod (inp_prod_ff),
      .res  (state_mixed)
   );

   assign state_in = inp_has_ff ? state_mixed : state_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
      end else if (inp_active) begin
         in_message_ff <= !inp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (inp_active) begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------ finalisation path
   // State one becomes the fake block and is replaced by the seed.
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (fin_ready) begin
         fin_v_ff <= inp_v_ff && inp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_ready && inp_go && inp_last_ff) begin
         fin_fake_lo_ff  <= state_in.s1_lo;
         fin_fake_hi_ff  <= state_in.s1_hi;
         fin_st_ff.s1_lo <= seed_lo_ff;
         fin_st_ff.s1_hi <= seed_hi_ff;
         fin_st_ff.s2_lo <= state_in.s2_lo;
         fin_st_ff.s2_hi <= state_in.s2_hi;
      end
   end

   msmh_mul u_fin_mul (
      .coef  (coef_ff),
      .in_lo (fin_fake_lo_ff),
      .in_hi (fin_fake_hi_ff),
      .prod  (fpr_prod_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fpr_v_ff <= 1'b0;
      end else if (fpr_ready) begin
         fpr_v_ff <= fin_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fpr_ready && fin_v_ff) begin
         fpr_prod_ff <= fpr_prod_in;
         fpr_st_ff   <= fin_st_ff;
      end
   end

   msmh_mix u_fin_mix (
      .st   (fpr_st_ff),
      .prod (fpr_prod_ff),
      .res  (fin_res)
   );

   // ---------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= fpr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && fpr_v_ff) begin
         rsp_hash_ff <= fin_res.s1_lo[31:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

`ifndef SYNTHESIS
   // A new result only appears when the finalisation stage held an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fpr_v_ff))
      else $error("result appeared without a finalisation item");

   // A last item blocked by a full finalisation stage stays in the input stage.
   assert property (@(posedge clock) disable iff (reset)
      (inp_v_ff && inp_last_ff && !fin_ready) |=> (inp_v_ff && inp_last_ff))
      else $error("blocked last item was lost");

   // Finishing a message always returns the block to between messages.
   assert property (@(posedge clock) disable iff (reset)
      (inp_go && inp_last_ff) |=> (!in_message_ff && fin_v_ff))
      else $error("message end not handed to finalisation");
`endif

endmodule

[rtl/msmh_mul.sv]
// Four independent 32x32 products of the block words with the coefficients.
module msmh_mul (
   input  msmh_pkg::coef_type  coef,
   input  logic [63:0]         in_lo,
   input  logic [63:0]         in_hi,
   output msmh_pkg::lanes_type prod
);

   assign prod.s1_lo = {32'd0, coef.a} * {32'd0, in_hi[31:0]};
   assign prod.s1_hi = {32'd0, coef.b} * {32'd0, in_hi[63:32]};
   assign prod.s2_lo = {32'd0, coef.c} * {32'd0, in_lo[31:0]};
   assign prod.s2_hi = {32'd0, coef.d} * {32'd0, in_lo[63:32]};

endmodule

[rtl/msmh_mix.sv]
// One mix round: product subtract, lane spread, cross add and the shuffle steps.
module msmh_mix (
   input  msmh_pkg::lanes_type st,
   input  msmh_pkg::lanes_type prod,
   output msmh_pkg::lanes_type res
);

   function automatic logic [63:0] spread(input logic [63:0] x);
      logic [63:0] t;
      t = x ^ (x >> 29);
      t = t + (t << 16);
      t = t ^ (t >> 21);
      return t;
   endfunction

   logic [63:0] y1_lo, y1_hi, y2_lo, y2_hi;
   logic [63:0] c1_lo, c1_hi, c2_lo, c2_hi;
   logic [63:0] u1_lo, u1_hi, v2_lo, v2_hi;
   logic [63:0] w1_lo, w1_hi, x2_lo, x2_hi;
   logic [63:0] z1_lo, z1_hi;

   always_comb begin
      y1_lo = spread(st.s1_lo - prod.s1_lo);
      y1_hi = spread(st.s1_hi - prod.s1_hi);
      y2_lo = spread(st.s2_lo - prod.s2_lo);
      y2_hi = spread(st.s2_hi - prod.s2_hi);

      // The whole 128-bit state shifted left by one word is added lane by lane.
      c1_lo = y1_lo + {y1_lo[31:0], 32'd0};
      c1_hi = y1_hi + {y1_hi[31:0], y1_lo[63:32]};
      c2_lo = y2_lo + {y2_lo[31:0], 32'd0};
      c2_hi = y2_hi + {y2_hi[31:0], y2_lo[63:32]};

      u1_lo = c1_lo - c2_lo;
      u1_hi = c1_hi - c2_hi;
      // State two rotated right by one word.
      v2_lo = {c2_hi[31:0], c2_lo[63:32]} - u1_lo;
      v2_hi = {c2_lo[31:0], c2_hi[63:32]} - u1_hi;
      // State one with its words reordered to (2,3,1,0).
      w1_lo = u1_hi - v2_lo;
      w1_hi = {u1_lo[31:0], u1_lo[63:32]} - v2_hi;
      // State two rotated left by one word.
      x2_lo = {v2_lo[31:0], v2_hi[63:32]} - w1_lo;
      x2_hi = {v2_hi[31:0], v2_lo[63:32]} - w1_hi;
      // State one rotated left by one word.
      z1_lo = {w1_lo[31:0], w1_hi[63:32]} - x2_lo;
      z1_hi = {w1_hi[31:0], w1_lo[63:32]} - x2_hi;

      res.s1_lo = z1_lo;
      res.s1_hi = z1_hi;
      res.s2_lo = x2_lo;
      res.s2_hi = x2_hi;
   end

endmodule

[sim/multiply_shift_mix_hash_128_tb.sv]
// Self-checking testbench for the 128-bit multiply-shift-mix hash block.
module multiply_shift_mix_hash_128_tb;

   localparam int unsigned SettleCycles = 12;
   localparam int unsigned QuietLimit   = 5000;
   localparam int unsigned LongHold     = 400;
   localparam int unsigned PhaseItems   = 190;
   localparam int unsigned NumPhases    = 8;
   localparam int unsigned PressurePhase = 4;

   typedef struct packed {
      logic [63:0] block_low;
      logic [63:0] block_high;
      logic        has_block;
      logic        is_last;
   } hash_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_block_low = '0;
   logic [63:0] req_block_high = '0;
   logic        req_has_block = 1'b0;
   logic        req_is_last = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_hash_value;

   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [msmh_pkg::CsrAddrWidth-1:0] paddr = '0;
   logic [msmh_pkg::CsrDataWidth-1:0] pwdata = '0;
   logic [msmh_pkg::CsrDataWidth-1:0] prdata;
   logic                              pready;

   // Predictor copy of the registers and the running state.
   logic [31:0]         cf_a = msmh_pkg::CoefAReset;
   logic [31:0]         cf_b = msmh_pkg::CoefBReset;
   logic [31:0]         cf_c = msmh_pkg::CoefCReset;
   logic [31:0]         cf_d = msmh_pkg::CoefDReset;
   logic [63:0]         seed_lo = msmh_pkg::SeedLowReset;
   logic [63:0]         seed_hi = msmh_pkg::SeedHighReset;
   msmh_pkg::lanes_type hash_lanes;
   bit                  msg_open = 1'b0;

   hash_item_type pending_items[$];
   logic [31:0]   expected_hashes[$];

   int unsigned items_queued = 0;
   int unsigned items_taken = 0;
   int unsigned stim_count = 0;
   int unsigned errors = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   bit          send_idling = 1'b1;
   bit          recv_idling = 1'b1;
   bit          long_hold_req = 1'b0;

   multiply_shift_mix_hash_128 i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_block_low  (req_block_low),
      .req_block_high (req_block_high),
      .req_has_block  (req_has_block),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] xorshift_lane(input logic [63:0] x);
      x = x ^ (x >> 29);
      x = x + (x << 16);
      x = x ^ (x >> 21);
      return x;
   endfunction

   // One SSE2-style round: multiply-subtract, per-lane spreading, the 128-bit
   // shifted add, then the five subtract-and-shuffle steps.
   function automatic msmh_pkg::lanes_type mix_round(input msmh_pkg::lanes_type st,
                                                     input logic [63:0] in_lo,
                                                     input logic [63:0] in_hi);
      logic [63:0] s1_0, s1_1, s2_0, s2_1, a0, a1, t;
      s1_0 = st.s1_lo - {32'h0, cf_a} * {32'h0, in_hi[31:0]};
      s1_1 = st.s1_hi - {32'h0, cf_b} * {32'h0, in_hi[63:32]};
      s2_0 = st.s2_lo - {32'h0, cf_c} * {32'h0, in_lo[31:0]};
      s2_1 = st.s2_hi - {32'h0, cf_d} * {32'h0, in_lo[63:32]};
      s1_0 = xorshift_lane(s1_0);
      s1_1 = xorshift_lane(s1_1);
      s2_0 = xorshift_lane(s2_0);
      s2_1 = xorshift_lane(s2_1);
      t = {s1_1[31:0], s1_0[63:32]};
      s1_0 = s1_0 + {s1_0[31:0], 32'h0};
      s1_1 = s1_1 + t;
      t = {s2_1[31:0], s2_0[63:32]};
      s2_0 = s2_0 + {s2_0[31:0], 32'h0};
      s2_1 = s2_1 + t;
      s1_0 = s1_0 - s2_0;
      s1_1 = s1_1 - s2_1;
      a0 = {s2_1[31:0], s2_0[63:32]};
      a1 = {s2_0[31:0], s2_1[63:32]};
      s2_0 = a0 - s1_0;
      s2_1 = a1 - s1_1;
      a0 = s1_1;
      a1 = {s1_0[31:0], s1_0[63:32]};
      s1_0 = a0 - s2_0;
      s1_1 = a1 - s2_1;
      a0 = {s2_0[31:0], s2_1[63:32]};
      a1 = {s2_1[31:0], s2_0[63:32]};
      s2_0 = a0 - s1_0;
      s2_1 = a1 - s1_1;
      a0 = {s1_0[31:0], s1_1[63:32]};
      a1 = {s1_1[31:0], s1_0[63:32]};
      s1_0 = a0 - s2_0;
      s1_1 = a1 - s2_1;
      mix_round.s1_lo = s1_0;
      mix_round.s1_hi = s1_1;
      mix_round.s2_lo = s2_0;
      mix_round.s2_hi = s2_1;
   endfunction

   // Folds one accepted transfer into the predicted state and queues the hash
   // when the message is closed.
   function automatic void absorb_item(input hash_item_type it);
      logic [63:0] f_lo, f_hi;
      if (!it.has_block && !it.is_last) return;
      if (!msg_open) begin
         hash_lanes.s1_lo = seed_lo;
         hash_lanes.s1_hi = seed_hi;
         hash_lanes.s2_lo = seed_lo;
         hash_lanes.s2_hi = seed_hi;
         msg_open = 1'b1;
      end
      if (it.has_block) hash_lanes = mix_round(hash_lanes, it.block_low, it.block_high);
      if (!it.is_last) return;
      // Finalisation: state one becomes the input and is reloaded from the seed.
      f_lo = hash_lanes.s1_lo;
      f_hi = hash_lanes.s1_hi;
      hash_lanes.s1_lo = seed_lo;
      hash_lanes.s1_hi = seed_hi;
      hash_lanes = mix_round(hash_lanes, f_lo, f_hi);
      expected_hashes.push_back(hash_lanes.s1_lo[31:0]);
      msg_open = 1'b0;
   endfunction

   function automatic logic [63:0] rand_word64();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [31:0] rand_word32();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_item(input logic [63:0] lo, input logic [63:0] hi,
                                    input logic hb, input logic last);
      pending_items.push_back('{lo, hi, hb, last});
      items_queued++;
      if (hb || last) stim_count++;
   endfunction

   // Queues one message of random blocks; occasional idle items are mixed in.
   // An open message is left unfinished so that a later phase closes it.
   task automatic add_message(input bit leave_open);
      int unsigned n;
      bit          finish_apart;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      finish_apart = (n == 0) || ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < n; k++) begin
         if ($urandom_range(0, 19) == 0) add_item(rand_word64(), rand_word64(), 1'b0, 1'b0);
         add_item(rand_word64(), rand_word64(), 1'b1,
                  !leave_open && !finish_apart && (k == n - 1));
      end
      if (!leave_open && finish_apart) add_item(rand_word64(), rand_word64(), 1'b0, 1'b1);
   endtask

   task automatic write_csr(input msmh_pkg::reg_index_type idx, input logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         msmh_pkg::REG_COEF_A:    cf_a = value[31:0];
         msmh_pkg::REG_COEF_B:    cf_b = value[31:0];
         msmh_pkg::REG_COEF_C:    cf_c = value[31:0];
         msmh_pkg::REG_COEF_D:    cf_d = value[31:0];
         msmh_pkg::REG_SEED_LOW:  seed_lo = value;
         msmh_pkg::REG_SEED_HIGH: seed_hi = value;
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d,
                               input logic [63:0] slo, input logic [63:0] shi);
      write_csr(msmh_pkg::REG_COEF_A, {32'h0, a});
      write_csr(msmh_pkg::REG_COEF_B, {32'h0, b});
      write_csr(msmh_pkg::REG_COEF_C, {32'h0, c});
      write_csr(msmh_pkg::REG_COEF_D, {32'h0, d});
      write_csr(msmh_pkg::REG_SEED_LOW, slo);
      write_csr(msmh_pkg::REG_SEED_HIGH, shi);
   endtask

   // Waits until every queued item has been taken and every hash has arrived,
   // then lets a non-final block that is still in flight drain.
   task automatic settle();
      while (items_taken != items_queued || expected_hashes.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Input driver.
   always @(posedge clock) begin
      hash_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_item({req_block_low, req_block_high, req_has_block, req_is_last});
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               next_item = pending_items.pop_front();
               req_block_low  <= next_item.block_low;
               req_block_high <= next_item.block_high;
               req_has_block  <= next_item.has_block;
               req_is_last    <= next_item.is_last;
               req_valid      <= 1'b1;
               if (send_idling && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor; it also drives the receiver's stall.
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               $error("hash_value: expected nothing, actual %h", rsp_hash_value);
               errors++;
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_hash_value !== want) begin
                  $error("hash_value: expected %h, actual %h", want, rsp_hash_value);
                  errors++;
               end
            end
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_idling && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 9) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Ends the run when nothing has been transferred for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("** multiply_shift_mix_hash_128: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int unsigned target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset configuration.
      add_item(rand_word64(), rand_word64(), 1'b0, 1'b1);        // empty message
      add_item('0, '0, 1'b1, 1'b1);
      add_item('1, '1, 1'b1, 1'b1);
      add_item('1, '0, 1'b1, 1'b0);
      add_item(rand_word64(), rand_word64(), 1'b0, 1'b0);        // idle item mid-message
      add_item('0, '1, 1'b1, 1'b0);
      add_item('0, '0, 1'b0, 1'b1);                              // finalise what was absorbed
      add_item({16{4'h5}}, {16{4'hA}}, 1'b1, 1'b0);
      add_item({16{4'hA}}, {16{4'h5}}, 1'b1, 1'b1);
      add_item(rand_word64(), rand_word64(), 1'b0, 1'b0);
      add_item({32'hFFFF_FFFF, 32'h0}, {32'h0, 32'hFFFF_FFFF}, 1'b1, 1'b1);
      add_item(rand_word64(), rand_word64(), 1'b1, 1'b0);        // left open across the seed write
      settle();
      write_csr(msmh_pkg::REG_SEED_LOW, rand_word64());
      write_csr(msmh_pkg::REG_SEED_HIGH, rand_word64());
      add_item(rand_word64(), rand_word64(), 1'b1, 1'b0);
      add_item(rand_word64(), rand_word64(), 1'b1, 1'b1);
      add_item(rand_word64(), rand_word64(), 1'b0, 1'b1);
      add_item(rand_word64(), rand_word64(), 1'b0, 1'b1);
      settle();

      for (int unsigned p = 0; p < NumPhases; p++) begin
         case (p)
            0: write_config('0, '0, '0, '0, '0, '0);
            1: write_config('1, '1, '1, '1, '1, '1);
            2: write_config(msmh_pkg::CoefAReset, msmh_pkg::CoefBReset,
                            msmh_pkg::CoefCReset, msmh_pkg::CoefDReset,
                            msmh_pkg::SeedLowReset, msmh_pkg::SeedHighReset);
            default: write_config(rand_word32(), rand_word32(), rand_word32(), rand_word32(),
                                  rand_word64(), rand_word64());
         endcase
         send_idling = (p != NumPhases - 1) && (p != PressurePhase);
         recv_idling = (p != NumPhases - 1);
         // Hold the result side off while the sender keeps offering items.
         if (p == PressurePhase) long_hold_req = 1'b1;
         target = stim_count + PhaseItems;
         while (stim_count < target) add_message(1'b0);
         if (p % 2 == 1 && p != NumPhases - 1) add_message(1'b1);
         settle();
      end

      if (errors == 0) begin
         $display("** multiply_shift_mix_hash_128: PASSED **");
      end else begin
         $display("** multiply_shift_mix_hash_128: FAILED **");
      end
      $finish;
   end

endmodule

[multiply_shift_mix_hash_128.f]
rtl/msmh_pkg.sv
rtl/msmh_mul.sv
rtl/msmh_mix.sv
rtl/multiply_shift_mix_hash_128.sv
sim/multiply_shift_mix_hash_128_tb.sv
